@@ hw/rtl/crcfr_pkg.sv @@
package crcfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int CRC_W   = 16;
  localparam int VERD_W  = 2;

  localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT  = 16'h0000;
  localparam logic [BYTE_W-1:0] FRAME_END = 8'h03;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [VERD_W-1:0] VERDICT_OK    = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_CRC   = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_TERM  = 2'd2;
  localparam logic [VERD_W-1:0] VERDICT_TRUNC = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEN  = 3'd1,
    PH_DATA = 3'd2,
    PH_CRCH = 3'd3,
    PH_CRCL = 3'd4,
    PH_TERM = 3'd5
  } phase_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic [VERD_W-1:0] verdict;
  } result_t;

  typedef struct packed {
    logic out_full;
    logic skid_full;
  } buf_status_t;

  // MSB-first CRC-16 update over one byte, eight shift steps.
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (crc[CRC_W-1]) begin
        crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[CRC_W-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

@@ hw/rtl/crcfr_parser.sv @@
module crcfr_parser (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [crcfr_pkg::BYTE_W-1:0]         rx_byte,
  input  logic                                 starts_packet,
  output logic                                 res_valid,
  output crcfr_pkg::result_t                   res
);

  crcfr_pkg::phase_t                 phase_r, phase_nxt;
  logic [crcfr_pkg::BYTE_W-1:0]      len_r, len_nxt;
  logic [crcfr_pkg::BYTE_W-1:0]      cnt_r, cnt_nxt;
  logic [crcfr_pkg::CRC_W-1:0]       crc_r, crc_nxt;
  logic [crcfr_pkg::CRC_W-1:0]       rcrc_r, rcrc_nxt;
  logic [crcfr_pkg::BYTE_W-1:0]      cnt_inc;

  assign cnt_inc = cnt_r + 8'd1;

  always_comb begin
    phase_nxt         = phase_r;
    len_nxt           = len_r;
    cnt_nxt           = cnt_r;
    crc_nxt           = crc_r;
    rcrc_nxt          = rcrc_r;
    res_valid         = 1'b0;
    res.kind          = crcfr_pkg::KIND_VERDICT;
    res.payload_byte  = '0;
    res.payload_index = '0;
    res.verdict       = crcfr_pkg::VERDICT_OK;

    if (starts_packet) begin
      // A start inside an open packet closes it as truncated.
      phase_nxt   = crcfr_pkg::PH_LEN;
      crc_nxt     = crcfr_pkg::CRC_INIT;
      cnt_nxt     = '0;
      res_valid   = (phase_r != crcfr_pkg::PH_IDLE);
      res.verdict = crcfr_pkg::VERDICT_TRUNC;
    end else begin
      unique case (phase_r)
        crcfr_pkg::PH_LEN: begin
          len_nxt   = rx_byte;
          cnt_nxt   = '0;
          crc_nxt   = crcfr_pkg::CRC_INIT;
          phase_nxt = (rx_byte == '0) ? crcfr_pkg::PH_CRCH : crcfr_pkg::PH_DATA;
        end
        crcfr_pkg::PH_DATA: begin
          crc_nxt           = crcfr_pkg::crc16_byte(crc_r, rx_byte);
          res_valid         = 1'b1;
          res.kind          = crcfr_pkg::KIND_DATA;
          res.payload_byte  = rx_byte;
          res.payload_index = cnt_r;
          cnt_nxt           = cnt_inc;
          if (cnt_inc == len_r) begin
            phase_nxt = crcfr_pkg::PH_CRCH;
          end
        end
        crcfr_pkg::PH_CRCH: begin
          rcrc_nxt  = {rx_byte, 8'h00};
          phase_nxt = crcfr_pkg::PH_CRCL;
        end
        crcfr_pkg::PH_CRCL: begin
          rcrc_nxt  = {rcrc_r[crcfr_pkg::CRC_W-1:crcfr_pkg::BYTE_W], rx_byte};
          phase_nxt = crcfr_pkg::PH_TERM;
        end
        crcfr_pkg::PH_TERM: begin
          res_valid = 1'b1;
          phase_nxt = crcfr_pkg::PH_IDLE;
          // A CRC mismatch outranks a bad terminator.
          if (crc_r != rcrc_r) begin
            res.verdict = crcfr_pkg::VERDICT_CRC;
          end else if (rx_byte != crcfr_pkg::FRAME_END) begin
            res.verdict = crcfr_pkg::VERDICT_TERM;
          end else begin
            res.verdict = crcfr_pkg::VERDICT_OK;
          end
        end
        default: begin
          phase_nxt = crcfr_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= crcfr_pkg::PH_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
      crc_r   <= crcfr_pkg::CRC_INIT;
      rcrc_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      rcrc_r  <= rcrc_nxt;
    end
  end

endmodule

@@ hw/rtl/crcfr_outbuf.sv @@
module crcfr_outbuf (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  crcfr_pkg::result_t       res_in,
  input  logic                     out_stall,
  output logic                     out_valid,
  output crcfr_pkg::result_t       res_out,
  output crcfr_pkg::buf_status_t   status
);

  logic                 out_valid_r;
  logic                 skid_valid_r;
  crcfr_pkg::result_t   out_res_r;
  crcfr_pkg::result_t   skid_res_r;
  logic                 slot_free;

  // The output slot can take a new request when it is empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (slot_free) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (slot_free) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (slot_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (slot_free) begin
        out_res_r <= skid_res_r;
      end
    end else if (push) begin
      if (slot_free) begin
        out_res_r <= res_in;
      end else begin
        skid_res_r <= res_in;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign res_out          = out_res_r;
  assign status.out_full  = out_valid_r;
  assign status.skid_full = skid_valid_r;

endmodule

@@ hw/rtl/crc_frame_receiver_top.sv @@
// Channel   Direction  Handshake        Payload
// in_       input      in_valid/stall   rx_byte, starts_packet
// out_      output     out_valid/stall  kind, payload_byte, payload_index, verdict
//
// One byte is taken per cycle while in_stall is low; its request, if any, is
// registered in the output buffer before it is shown on the out_ channel.
// The CRC update of a byte is an eight-step combinational shift network.
// Reset is synchronous and active low; it returns the framer to idle.
// A two-entry output buffer lets the input run while one request waits;
// in_stall rises only when both entries are occupied.
module crc_frame_receiver_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [crcfr_pkg::BYTE_W-1:0]        in_rx_byte,
  input  logic                                in_starts_packet,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kind,
  output logic [crcfr_pkg::BYTE_W-1:0]        out_payload_byte,
  output logic [crcfr_pkg::BYTE_W-1:0]        out_payload_index,
  output logic [crcfr_pkg::VERD_W-1:0]        out_verdict
);

  logic                    accept;
  logic                    res_valid;
  crcfr_pkg::result_t      res;
  crcfr_pkg::result_t      res_out;
  crcfr_pkg::buf_status_t  status;

  assign in_stall = status.skid_full;
  assign accept   = in_valid && !in_stall;

  crcfr_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .rx_byte       (in_rx_byte),
    .starts_packet (in_starts_packet),
    .res_valid     (res_valid),
    .res           (res)
  );

  crcfr_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .res_in    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (res_out),
    .status    (status)
  );

  assign out_kind          = res_out.kind;
  assign out_payload_byte  = res_out.payload_byte;
  assign out_payload_index = res_out.payload_index;
  assign out_verdict       = res_out.verdict;

  // The skid entry is only ever filled behind a full output slot.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    status.skid_full |-> status.out_full)
    else $error("skid entry holds a request while the output slot is empty");

  // A full skid entry must drain into the output once the output moves.
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (status.skid_full && !out_stall) |=> (out_valid && !status.skid_full))
    else $error("skid entry did not move to the output");

  a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == crcfr_pkg::KIND_VERDICT) |->
      (out_payload_byte == '0 && out_payload_index == '0))
    else $error("verdict request carries payload fields");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == crcfr_pkg::KIND_DATA) |->
      (out_verdict == crcfr_pkg::VERDICT_OK))
    else $error("payload request carries a verdict");

endmodule
